FILE: hdl/wfps_pkg.sv
// ----------------------------------------------------------------------------
// Wall-following steering: shared package
// Widths, codes, register indexes and item types used by the steering block.
// ----------------------------------------------------------------------------
package wfps_pkg;

	localparam int RAW_W     = 7;
	localparam int CM_W      = 9;
	localparam int DIST_W    = 15;
	localparam int GAIN_W    = 16;
	localparam int ERR_W     = 16;
	localparam int DIFF_W    = 17;
	localparam int INTEG_W   = 18;
	localparam int SPEED_W   = 8;
	localparam int DIV_W     = 20;
	localparam int PART_W    = 20;
	localparam int ACC_W     = 37;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam int MAX_RANGE_CM_DEF   = 100;
	localparam int STUCK_LIMIT_Q8_DEF = 512;
	localparam int FRACTION_BITS_DEF  = 8;

	localparam logic [DIST_W-1:0] DIST_MAX = 15'h7FFF;
	localparam int FOLLOW_CAP_CM     = 20;
	localparam int FOLLOW_STEER_LIM  = 40;
	localparam int FOLLOW_SPEED_MIN  = 50;
	localparam int FOLLOW_SPEED_MAX  = 150;
	localparam int INTEG_MAX         = 131071;
	localparam int INTEG_MIN         = -131072;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_TWO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_ONE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRONT_LIMIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SIDE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED  = 3'd7;

	localparam logic [GAIN_W-1:0]  GAIN_P_TWO_RST  = 16'd3200;
	localparam logic [GAIN_W-1:0]  GAIN_P_ONE_RST  = 16'd1408;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST      = 16'd128;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST      = 16'd0;
	localparam logic [DIST_W-1:0]  SIDE_LIMIT_RST  = 15'd3866;
	localparam logic [DIST_W-1:0]  FRONT_LIMIT_RST = 15'd3200;
	localparam logic [DIST_W-1:0]  TARGET_SIDE_RST = 15'd2560;
	localparam logic [SPEED_W-1:0] BASE_SPEED_RST  = 8'd100;

	localparam logic [1:0] ACT_ESCAPE = 2'd0;
	localparam logic [1:0] ACT_TURN   = 2'd1;
	localparam logic [1:0] ACT_CENTER = 2'd2;
	localparam logic [1:0] ACT_FOLLOW = 2'd3;

	localparam logic [2:0] TURN_NONE     = 3'd0;
	localparam logic [2:0] TURN_U        = 3'd1;
	localparam logic [2:0] TURN_RIGHT_90 = 3'd2;
	localparam logic [2:0] TURN_LEFT_90  = 3'd3;
	localparam logic [2:0] TURN_RIGHT_85 = 3'd4;

	localparam logic [1:0] ESC_BACK       = 2'd0;
	localparam logic [1:0] ESC_SPIN_RIGHT = 2'd1;
	localparam logic [1:0] ESC_SPIN_LEFT  = 2'd2;

	typedef struct packed {
		logic [RAW_W-1:0] left_raw_cm;
		logic [RAW_W-1:0] front_raw_cm;
		logic [RAW_W-1:0] right_raw_cm;
	} sonar_item_t;

	typedef struct packed {
		logic [1:0]         action_kind;
		logic [2:0]         turn_kind;
		logic [1:0]         escape_kind;
		logic [SPEED_W-1:0] left_speed;
		logic [SPEED_W-1:0] right_speed;
		logic               left_wall_seen;
		logic               right_wall_seen;
		logic               front_wall_seen;
	} steer_item_t;

	typedef struct packed {
		logic [GAIN_W-1:0]         gp;
		logic [GAIN_W-1:0]         gd;
		logic [GAIN_W-1:0]         gi;
		logic signed [ERR_W-1:0]   e;
		logic signed [DIFF_W-1:0]  d;
		logic signed [INTEG_W-1:0] ig;
	} mac_in_t;

endpackage

FILE: hdl/wall_following_pid_steering.sv
// ----------------------------------------------------------------------------
// Wall-following PID steering controller
// Smooths three sonar distances, sets wall flags and picks escape, turn,
// centring or one-wall following, with a serial PID for the steering cases.
// ----------------------------------------------------------------------------
//   Channel  Signals                            Direction  Width
//   sonar    sonar_valid, sonar_ready, sonar    in         21
//   steer    steer_valid, steer_ready, steer    out        26
//   cfg      cfg_we, cfg_index, cfg_data        in         1 + 3 + 16
//
// One item is worked on at a time. An escape or turn item goes from the decision
// state to the finish state. A steering item passes the decision state, the ten digit
// steps of the divide by three, a hand-off, the sixteen gain bits of the multiply-
// accumulate and the speed and item registers. The finish state offers each item.
// The result register lets the next item be accepted while a result waits.
// Reset clears the smoothed distances and the PID state and reloads register defaults.
module wall_following_pid_steering import wfps_pkg::*; #(
	parameter int MAX_RANGE_CM   = MAX_RANGE_CM_DEF,
	parameter int STUCK_LIMIT_Q8 = STUCK_LIMIT_Q8_DEF,
	parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sonar_valid,
	output logic                 sonar_ready,
	input  sonar_item_t          sonar,
	output logic                 steer_valid,
	input  logic                 steer_ready,
	output steer_item_t          steer,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_MAC    = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	localparam int SHIFT_W = CM_W + FRACTION_BITS;
	localparam int CAP_RAW = FOLLOW_CAP_CM << FRACTION_BITS;
	localparam logic [DIST_W-1:0] CAP_Q =
		(CAP_RAW > 32767) ? DIST_MAX : DIST_W'(CAP_RAW);
	localparam logic [DIST_W-1:0] STUCK_Q = DIST_W'(STUCK_LIMIT_Q8);
	localparam logic signed [ACC_W-1:0] STEER_LO = ACC_W'(-FOLLOW_STEER_LIM);
	localparam logic signed [ACC_W-1:0] STEER_HI = ACC_W'(FOLLOW_STEER_LIM);
	localparam logic signed [9:0] FSPEED_LO = 10'(FOLLOW_SPEED_MIN);
	localparam logic signed [9:0] FSPEED_HI = 10'(FOLLOW_SPEED_MAX);
	localparam logic signed [DIV_W:0] INTEG_HI = (DIV_W+1)'(INTEG_MAX);
	localparam logic signed [DIV_W:0] INTEG_LO = (DIV_W+1)'(INTEG_MIN);

	function automatic logic [DIST_W-1:0] to_fixed(input logic [RAW_W-1:0] raw);
		logic [CM_W-1:0]    cm;
		logic [SHIFT_W-1:0] q;
		cm = (raw == '0) ? CM_W'(MAX_RANGE_CM) : {{(CM_W-RAW_W){1'b0}}, raw};
		q  = {{FRACTION_BITS{1'b0}}, cm} << FRACTION_BITS;
		return (q > SHIFT_W'(DIST_MAX)) ? DIST_MAX : q[DIST_W-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] smooth(input logic [DIST_W-1:0] s,
		input logic [DIST_W-1:0] old);
		logic [DIST_W:0] total;
		total = {1'b0, s} + {1'b0, old};
		return total[DIST_W:1];
	endfunction

	logic [2:0] state_q;

	logic [GAIN_W-1:0]  gain_p_two_q;
	logic [GAIN_W-1:0]  gain_p_one_q;
	logic [GAIN_W-1:0]  gain_d_q;
	logic [GAIN_W-1:0]  gain_i_q;
	logic [DIST_W-1:0]  side_limit_q;
	logic [DIST_W-1:0]  front_limit_q;
	logic [DIST_W-1:0]  target_side_q;
	logic [SPEED_W-1:0] base_speed_q;

	logic [DIST_W-1:0]         left_sm_q;
	logic [DIST_W-1:0]         right_sm_q;
	logic [DIST_W-1:0]         front_sm_q;
	logic signed [ERR_W-1:0]   prev_err_q;
	logic signed [INTEG_W-1:0] integ_q;

	logic signed [ERR_W-1:0]   e_q;
	logic signed [DIFF_W-1:0]  d_q;
	logic signed [INTEG_W-1:0] integ_new_q;
	logic                      center_q;
	logic                      neg_q;
	steer_item_t               res_q;
	steer_item_t               steer_q;
	logic                      steer_valid_q;

	logic                      lw;
	logic                      rw;
	logic                      fw;
	logic                      stuck_l;
	logic                      stuck_r;
	logic                      stuck_f;
	logic                      pid_go;
	logic [DIST_W-1:0]         safe_r;
	logic signed [ERR_W-1:0]   e_new;
	logic signed [DIV_W-1:0]   twice_i;
	logic [DIV_W-1:0]          div_arg;
	logic                      div_start;
	logic                      div_done;
	logic [DIV_W-1:0]          div_q;
	logic signed [DIV_W-1:0]   floor_q;
	logic signed [DIV_W:0]     integ_sum;
	logic signed [INTEG_W-1:0] integ_sat;
	logic                      mac_start;
	logic                      mac_done;
	logic signed [ACC_W-1:0]   mac_sum;
	mac_in_t                   mac_ops;
	logic signed [ACC_W-1:0]   steer_val;
	logic signed [ACC_W:0]     base_ext;
	logic signed [ACC_W:0]     steer_ext;
	logic signed [ACC_W:0]     c_right;
	logic signed [ACC_W:0]     c_left;
	logic [SPEED_W-1:0]        c_right_spd;
	logic [SPEED_W-1:0]        c_left_spd;
	logic signed [ACC_W-1:0]   f_steer_wide;
	logic signed [9:0]         f_steer;
	logic signed [9:0]         f_right;
	logic signed [9:0]         f_left;
	logic [SPEED_W-1:0]        f_right_spd;
	logic [SPEED_W-1:0]        f_left_spd;
	logic                      out_free;

	always_comb begin
		lw      = left_sm_q < side_limit_q;
		rw      = right_sm_q < side_limit_q;
		fw      = front_sm_q < front_limit_q;
		stuck_l = left_sm_q < STUCK_Q;
		stuck_r = right_sm_q < STUCK_Q;
		stuck_f = front_sm_q < STUCK_Q;
		pid_go  = !(stuck_l || stuck_r || stuck_f) && !fw;
		safe_r  = (right_sm_q < CAP_Q) ? right_sm_q : CAP_Q;
		if (lw && rw) begin
			e_new = $signed({1'b0, left_sm_q}) - $signed({1'b0, right_sm_q});
		end else begin
			e_new = $signed({1'b0, target_side_q}) - $signed({1'b0, safe_r});
		end
		twice_i   = {integ_q[INTEG_W-1], integ_q, 1'b0};
		div_arg   = twice_i[DIV_W-1] ? DIV_W'(-twice_i) + DIV_W'(2) : twice_i;
		div_start = (state_q == ST_DECIDE) && pid_go;
	end

	wfps_div3 u_div3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_arg),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		floor_q   = neg_q ? -$signed(div_q) : $signed(div_q);
		integ_sum = {floor_q[DIV_W-1], floor_q} +
			{{(DIV_W+1-ERR_W){e_q[ERR_W-1]}}, e_q};
		if (integ_sum > INTEG_HI) begin
			integ_sat = INTEG_W'(INTEG_MAX);
		end else if (integ_sum < INTEG_LO) begin
			integ_sat = INTEG_W'(INTEG_MIN);
		end else begin
			integ_sat = integ_sum[INTEG_W-1:0];
		end
		mac_start  = (state_q == ST_DIV) && div_done;
		mac_ops.gp = center_q ? gain_p_two_q : gain_p_one_q;
		mac_ops.gd = gain_d_q;
		mac_ops.gi = gain_i_q;
		mac_ops.e  = e_q;
		mac_ops.d  = d_q;
		mac_ops.ig = integ_sat;
	end

	wfps_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.ops    (mac_ops),
		.done   (mac_done),
		.sum    (mac_sum)
	);

	always_comb begin
		steer_val = mac_sum >>> (2 * FRACTION_BITS);
		base_ext  = {{(ACC_W+1-SPEED_W){1'b0}}, base_speed_q};
		steer_ext = {steer_val[ACC_W-1], steer_val};
		c_right   = base_ext + steer_ext;
		c_left    = base_ext - steer_ext;
		if (c_right[ACC_W]) begin
			c_right_spd = '0;
		end else if (|c_right[ACC_W-1:SPEED_W]) begin
			c_right_spd = '1;
		end else begin
			c_right_spd = c_right[SPEED_W-1:0];
		end
		if (c_left[ACC_W]) begin
			c_left_spd = '0;
		end else if (|c_left[ACC_W-1:SPEED_W]) begin
			c_left_spd = '1;
		end else begin
			c_left_spd = c_left[SPEED_W-1:0];
		end
		if (steer_val < STEER_LO) begin
			f_steer_wide = STEER_LO;
		end else if (steer_val > STEER_HI) begin
			f_steer_wide = STEER_HI;
		end else begin
			f_steer_wide = steer_val;
		end
		f_steer = f_steer_wide[9:0];
		f_right = $signed({2'b00, base_speed_q}) + f_steer;
		f_left  = $signed({2'b00, base_speed_q}) - f_steer;
		if (f_right < FSPEED_LO) begin
			f_right_spd = SPEED_W'(FOLLOW_SPEED_MIN);
		end else if (f_right > FSPEED_HI) begin
			f_right_spd = SPEED_W'(FOLLOW_SPEED_MAX);
		end else begin
			f_right_spd = f_right[SPEED_W-1:0];
		end
		if (f_left < FSPEED_LO) begin
			f_left_spd = SPEED_W'(FOLLOW_SPEED_MIN);
		end else if (f_left > FSPEED_HI) begin
			f_left_spd = SPEED_W'(FOLLOW_SPEED_MAX);
		end else begin
			f_left_spd = f_left[SPEED_W-1:0];
		end
		out_free = !steer_valid_q || steer_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_two_q  <= GAIN_P_TWO_RST;
			gain_p_one_q  <= GAIN_P_ONE_RST;
			gain_d_q      <= GAIN_D_RST;
			gain_i_q      <= GAIN_I_RST;
			side_limit_q  <= SIDE_LIMIT_RST;
			front_limit_q <= FRONT_LIMIT_RST;
			target_side_q <= TARGET_SIDE_RST;
			base_speed_q  <= BASE_SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P_TWO:  gain_p_two_q  <= cfg_data;
				REG_GAIN_P_ONE:  gain_p_one_q  <= cfg_data;
				REG_GAIN_D:      gain_d_q      <= cfg_data;
				REG_GAIN_I:      gain_i_q      <= cfg_data;
				REG_SIDE_LIMIT:  side_limit_q  <= cfg_data[DIST_W-1:0];
				REG_FRONT_LIMIT: front_limit_q <= cfg_data[DIST_W-1:0];
				REG_TARGET_SIDE: target_side_q <= cfg_data[DIST_W-1:0];
				default:         base_speed_q  <= cfg_data[SPEED_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			left_sm_q     <= '0;
			right_sm_q    <= '0;
			front_sm_q    <= '0;
			prev_err_q    <= '0;
			integ_q       <= '0;
			steer_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && out_free) begin
				steer_valid_q <= 1'b1;
			end else if (steer_valid_q && steer_ready) begin
				steer_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sonar_valid) begin
						left_sm_q  <= smooth(to_fixed(sonar.left_raw_cm), left_sm_q);
						front_sm_q <= smooth(to_fixed(sonar.front_raw_cm), front_sm_q);
						right_sm_q <= smooth(to_fixed(sonar.right_raw_cm), right_sm_q);
						state_q    <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (pid_go) begin
						state_q <= ST_DIV;
					end else begin
						prev_err_q <= '0;
						integ_q    <= '0;
						state_q    <= ST_FINISH;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (mac_done) begin
						if (center_q || res_q.right_wall_seen) begin
							prev_err_q <= e_q;
							integ_q    <= integ_new_q;
						end else begin
							prev_err_q <= '0;
							integ_q    <= '0;
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_DECIDE: begin
				res_q.left_wall_seen  <= lw;
				res_q.right_wall_seen <= rw;
				res_q.front_wall_seen <= fw;
				res_q.left_speed      <= '0;
				res_q.right_speed     <= '0;
				center_q              <= lw && rw;
				e_q                   <= e_new;
				d_q                   <= {e_new[ERR_W-1], e_new} -
					{prev_err_q[ERR_W-1], prev_err_q};
				neg_q                 <= twice_i[DIV_W-1];
				if (stuck_l || stuck_r || stuck_f) begin
					res_q.action_kind <= ACT_ESCAPE;
					res_q.turn_kind   <= TURN_NONE;
					if (stuck_l && !stuck_r) begin
						res_q.escape_kind <= ESC_SPIN_RIGHT;
					end else if (stuck_r && !stuck_l) begin
						res_q.escape_kind <= ESC_SPIN_LEFT;
					end else begin
						res_q.escape_kind <= ESC_BACK;
					end
				end else if (fw) begin
					res_q.action_kind <= ACT_TURN;
					res_q.escape_kind <= ESC_BACK;
					if (lw && rw) begin
						res_q.turn_kind <= TURN_U;
					end else if (lw) begin
						res_q.turn_kind <= TURN_RIGHT_90;
					end else if (rw) begin
						res_q.turn_kind <= TURN_LEFT_90;
					end else begin
						res_q.turn_kind <= TURN_RIGHT_85;
					end
				end else if (lw && rw) begin
					res_q.action_kind <= ACT_CENTER;
					res_q.turn_kind   <= TURN_NONE;
					res_q.escape_kind <= ESC_BACK;
				end else begin
					res_q.action_kind <= ACT_FOLLOW;
					res_q.turn_kind   <= TURN_NONE;
					res_q.escape_kind <= ESC_BACK;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					integ_new_q <= integ_sat;
				end
			end
			ST_MAC: begin
				if (mac_done) begin
					if (center_q) begin
						res_q.left_speed  <= c_left_spd;
						res_q.right_speed <= c_right_spd;
					end else begin
						res_q.left_speed  <= f_left_spd;
						res_q.right_speed <= f_right_spd;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					steer_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign sonar_ready = (state_q == ST_IDLE);
	assign steer_valid = steer_valid_q;
	assign steer       = steer_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		sonar_valid && sonar_ready |=> !sonar_ready)
		else $error("second item accepted while one is in flight");

	a_mac_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_MAC)
		else $error("multiply-accumulate finished outside its state");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside its state");

	a_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		steer_valid && (steer.action_kind == ACT_ESCAPE || steer.action_kind == ACT_TURN)
		|-> steer.left_speed == '0 && steer.right_speed == '0)
		else $error("motor duty given for an escape or turn item");

	a_follow_range: assert property (@(posedge clk) disable iff (!arst_n)
		steer_valid && steer.action_kind == ACT_FOLLOW
		|-> steer.left_speed >= SPEED_W'(FOLLOW_SPEED_MIN)
			&& steer.left_speed <= SPEED_W'(FOLLOW_SPEED_MAX)
			&& steer.right_speed >= SPEED_W'(FOLLOW_SPEED_MIN)
			&& steer.right_speed <= SPEED_W'(FOLLOW_SPEED_MAX))
		else $error("follow duty outside its clamp");

endmodule

FILE: hdl/wfps_div3.sv
// ----------------------------------------------------------------------------
// Wall-following steering: serial divide by three
// Radix-4 restoring division of an unsigned word by three, two bits a cycle.
// ----------------------------------------------------------------------------
module wfps_div3 import wfps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int STEPS = DIV_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] num_q;
	logic [DIV_W-1:0] quo_q;
	logic [1:0]       rem_q;
	logic [3:0]       trial;
	logic [1:0]       digit;
	logic [3:0]       rem_full;

	always_comb begin
		trial = {rem_q, num_q[DIV_W-1 -: 2]};
		if (trial >= 4'd9) begin
			digit = 2'd3;
		end else if (trial >= 4'd6) begin
			digit = 2'd2;
		end else if (trial >= 4'd3) begin
			digit = 2'd1;
		end else begin
			digit = 2'd0;
		end
		rem_full = trial - 4'(3 * digit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= 2'd0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-3:0], 2'b00};
			quo_q <= {quo_q[DIV_W-3:0], digit};
			rem_q <= rem_full[1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: hdl/wfps_mac.sv
// ----------------------------------------------------------------------------
// Wall-following steering: serial multiply-accumulate
// Forms Gp*e + Gd*d + Gi*i by walking the three gains one bit a cycle, MSB first.
// ----------------------------------------------------------------------------
module wfps_mac import wfps_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  mac_in_t                 ops,
	output logic                    done,
	output logic signed [ACC_W-1:0] sum
);

	localparam int CNT_W = $clog2(GAIN_W + 1);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [GAIN_W-1:0]         gp_q;
	logic [GAIN_W-1:0]         gd_q;
	logic [GAIN_W-1:0]         gi_q;
	logic signed [ERR_W-1:0]   e_q;
	logic signed [DIFF_W-1:0]  d_q;
	logic signed [INTEG_W-1:0] ig_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PART_W-1:0]  part_e;
	logic signed [PART_W-1:0]  part_d;
	logic signed [PART_W-1:0]  part_i;
	logic signed [PART_W-1:0]  partial;

	always_comb begin
		part_e  = gp_q[GAIN_W-1] ? {{(PART_W-ERR_W){e_q[ERR_W-1]}}, e_q} : '0;
		part_d  = gd_q[GAIN_W-1] ? {{(PART_W-DIFF_W){d_q[DIFF_W-1]}}, d_q} : '0;
		part_i  = gi_q[GAIN_W-1] ? {{(PART_W-INTEG_W){ig_q[INTEG_W-1]}}, ig_q} : '0;
		partial = part_e + part_d + part_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(GAIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			gp_q  <= ops.gp;
			gd_q  <= ops.gd;
			gi_q  <= ops.gi;
			e_q   <= ops.e;
			d_q   <= ops.d;
			ig_q  <= ops.ig;
			acc_q <= '0;
		end else if (busy_q) begin
			gp_q  <= {gp_q[GAIN_W-2:0], 1'b0};
			gd_q  <= {gd_q[GAIN_W-2:0], 1'b0};
			gi_q  <= {gi_q[GAIN_W-2:0], 1'b0};
			acc_q <= (acc_q <<< 1) + {{(ACC_W-PART_W){partial[PART_W-1]}}, partial};
		end
	end

	assign done = done_q;
	assign sum  = acc_q;

endmodule

FILE: tb/wall_following_pid_steering_test.sv
// ---------------------------------------------------------------------------
// Wall-following PID steering: self-checking testbench
// Sonar items go through the block under several register settings, with
// random idling on both channels. Each steering item that comes back is
// compared field by field with its pinned row or with a local model of the
// smoothing, wall flags, action choice and PID arithmetic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wall_following_pid_steering_test;
	import wfps_pkg::*;

	typedef struct packed {
		sonar_item_t reading;
		logic        pinned;
		steer_item_t want;
	} probe_row_t;

	typedef enum int {SET_MAX, SET_ZERO, SET_DEFAULT, SET_RANDOM} setting_t;

	localparam int PROBE_ROWS      = 24;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 205;
	localparam int SETTLE_CYCLES   = 40;

	localparam setting_t SETTING_PLAN [PHASES] = '{SET_MAX, SET_ZERO, SET_RANDOM, SET_DEFAULT,
		SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_DEFAULT};
	localparam int IDLE_PLAN  [4] = '{0, 83, 0, 29};
	localparam int STALL_PLAN [4] = '{0, 0, 83, 29};

	// The pinned rows walk the smoothed distances down from reset, through every
	// action, to a full stop and then to a stuck left side.
	localparam probe_row_t PROBES [PROBE_ROWS] = '{
		'{'{7'd0, 7'd0, 7'd0}, 1'b1,
			'{ACT_FOLLOW, TURN_NONE, ESC_BACK, 8'd140, 8'd60, 1'b0, 1'b0, 1'b0}},
		'{'{7'd1, 7'd1, 7'd1}, 1'b1,
			'{ACT_FOLLOW, TURN_NONE, ESC_BACK, 8'd140, 8'd60, 1'b0, 1'b0, 1'b0}},
		'{'{7'd1, 7'd1, 7'd1}, 1'b1,
			'{ACT_CENTER, TURN_NONE, ESC_BACK, 8'd100, 8'd100, 1'b1, 1'b1, 1'b0}},
		'{'{7'd1, 7'd1, 7'd1}, 1'b1,
			'{ACT_TURN, TURN_U, ESC_BACK, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1}},
		'{'{7'd1, 7'd1, 7'd1}, 1'b1,
			'{ACT_TURN, TURN_U, ESC_BACK, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1}},
		'{'{7'd1, 7'd1, 7'd1}, 1'b1,
			'{ACT_TURN, TURN_U, ESC_BACK, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1}},
		'{'{7'd1, 7'd1, 7'd1}, 1'b1,
			'{ACT_ESCAPE, TURN_NONE, ESC_BACK, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1}},
		'{'{7'd1, 7'd127, 7'd127}, 1'b1,
			'{ACT_ESCAPE, TURN_NONE, ESC_SPIN_RIGHT, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0}},
		'{'{7'd127, 7'd127, 7'd1}, 1'b0, '0},
		'{'{7'd127, 7'd127, 7'd1}, 1'b0, '0},
		'{'{7'd127, 7'd127, 7'd1}, 1'b0, '0},
		'{'{7'd127, 7'd127, 7'd1}, 1'b0, '0},
		'{'{7'd127, 7'd127, 7'd1}, 1'b0, '0},
		'{'{7'd127, 7'd127, 7'd1}, 1'b0, '0},
		'{'{7'd1, 7'd1, 7'd127}, 1'b0, '0},
		'{'{7'd1, 7'd1, 7'd127}, 1'b0, '0},
		'{'{7'd1, 7'd1, 7'd127}, 1'b0, '0},
		'{'{7'd1, 7'd1, 7'd127}, 1'b0, '0},
		'{'{7'd127, 7'd1, 7'd1}, 1'b0, '0},
		'{'{7'd127, 7'd1, 7'd1}, 1'b0, '0},
		'{'{7'd127, 7'd12, 7'd1}, 1'b0, '0},
		'{'{7'd127, 7'd12, 7'd1}, 1'b0, '0},
		'{'{7'd127, 7'd127, 7'd127}, 1'b0, '0},
		'{'{7'd64, 7'd32, 7'd16}, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sonar_valid = 1'b0;
	logic                 sonar_ready;
	sonar_item_t          sonar = '0;
	logic                 steer_valid;
	logic                 steer_ready = 1'b0;
	steer_item_t          steer;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	logic [GAIN_W-1:0]  k_p_two = GAIN_P_TWO_RST;
	logic [GAIN_W-1:0]  k_p_one = GAIN_P_ONE_RST;
	logic [GAIN_W-1:0]  k_d = GAIN_D_RST;
	logic [GAIN_W-1:0]  k_i = GAIN_I_RST;
	logic [DIST_W-1:0]  lim_side = SIDE_LIMIT_RST;
	logic [DIST_W-1:0]  lim_front = FRONT_LIMIT_RST;
	logic [DIST_W-1:0]  want_side = TARGET_SIDE_RST;
	logic [SPEED_W-1:0] cruise = BASE_SPEED_RST;

	logic [DIST_W-1:0] sm_left = '0;
	logic [DIST_W-1:0] sm_front = '0;
	logic [DIST_W-1:0] sm_right = '0;
	longint            last_err = 0;
	longint            integ = 0;

	steer_item_t steer_due [$];
	steer_item_t due_item;
	int          errors = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          scene_left = 0;
	int          scene_jit = 0;
	int          scene_base [3] = '{64, 64, 64};

	wall_following_pid_steering DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sonar_valid(sonar_valid),
		.sonar_ready(sonar_ready),
		.sonar(sonar),
		.steer_valid(steer_valid),
		.steer_ready(steer_ready),
		.steer(steer),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [DIST_W-1:0] cm_to_q(input longint cm);
		longint q;
		q = cm << FRACTION_BITS_DEF;
		return q > longint'(DIST_MAX) ? DIST_MAX : DIST_W'(q);
	endfunction

	function automatic longint pid_correction(input longint e, input logic [GAIN_W-1:0] gp);
		longint d, twice, leak, acc;
		d = e - last_err;
		twice = 2 * integ;
		leak = twice >= 0 ? twice / 3 : -((-twice + 2) / 3);
		integ = clamp(leak + e, INTEG_MIN, INTEG_MAX);
		last_err = e;
		acc = longint'(gp) * e + longint'(k_d) * d + longint'(k_i) * integ;
		return acc >>> (2 * FRACTION_BITS_DEF);
	endfunction

	function automatic steer_item_t predict_steer(input sonar_item_t s);
		logic [RAW_W-1:0]  raw [3];
		logic [DIST_W-1:0] q [3];
		logic [DIST_W-1:0] right_near;
		logic              stuck_l, stuck_r, stuck_f, wall_l, wall_r, wall_f;
		longint            corr;
		steer_item_t       r;
		raw[0] = s.left_raw_cm;
		raw[1] = s.front_raw_cm;
		raw[2] = s.right_raw_cm;
		for (int i = 0; i < 3; i++)
			q[i] = cm_to_q(raw[i] == 0 ? MAX_RANGE_CM_DEF : raw[i]);
		sm_left  = DIST_W'((int'(q[0]) + int'(sm_left)) >> 1);
		sm_front = DIST_W'((int'(q[1]) + int'(sm_front)) >> 1);
		sm_right = DIST_W'((int'(q[2]) + int'(sm_right)) >> 1);
		wall_l = sm_left < lim_side;
		wall_r = sm_right < lim_side;
		wall_f = sm_front < lim_front;
		stuck_l = sm_left < STUCK_LIMIT_Q8_DEF;
		stuck_r = sm_right < STUCK_LIMIT_Q8_DEF;
		stuck_f = sm_front < STUCK_LIMIT_Q8_DEF;
		r = '0;
		r.left_wall_seen = wall_l;
		r.right_wall_seen = wall_r;
		r.front_wall_seen = wall_f;
		if (stuck_l || stuck_r || stuck_f) begin
			r.action_kind = ACT_ESCAPE;
			if (stuck_l && !stuck_r)
				r.escape_kind = ESC_SPIN_RIGHT;
			else if (stuck_r && !stuck_l)
				r.escape_kind = ESC_SPIN_LEFT;
			last_err = 0;
			integ = 0;
		end else if (wall_f) begin
			r.action_kind = ACT_TURN;
			if (wall_l && wall_r)
				r.turn_kind = TURN_U;
			else if (wall_l)
				r.turn_kind = TURN_RIGHT_90;
			else if (wall_r)
				r.turn_kind = TURN_LEFT_90;
			else
				r.turn_kind = TURN_RIGHT_85;
			last_err = 0;
			integ = 0;
		end else if (wall_l && wall_r) begin
			corr = pid_correction(longint'(sm_left) - longint'(sm_right), k_p_two);
			r.action_kind = ACT_CENTER;
			r.right_speed = SPEED_W'(clamp(longint'(cruise) + corr, 0, 255));
			r.left_speed = SPEED_W'(clamp(longint'(cruise) - corr, 0, 255));
		end else begin
			right_near = sm_right < cm_to_q(FOLLOW_CAP_CM) ? sm_right : cm_to_q(FOLLOW_CAP_CM);
			corr = clamp(pid_correction(longint'(want_side) - longint'(right_near), k_p_one),
				-FOLLOW_STEER_LIM, FOLLOW_STEER_LIM);
			r.action_kind = ACT_FOLLOW;
			r.right_speed = SPEED_W'(clamp(longint'(cruise) + corr, FOLLOW_SPEED_MIN,
				FOLLOW_SPEED_MAX));
			r.left_speed = SPEED_W'(clamp(longint'(cruise) - corr, FOLLOW_SPEED_MIN,
				FOLLOW_SPEED_MAX));
			if (!wall_r) begin
				last_err = 0;
				integ = 0;
			end
		end
		return r;
	endfunction

	function automatic logic [RAW_W-1:0] jitter_cm(input int base, input int spread);
		return RAW_W'(clamp(base + int'($urandom_range(2 * spread)) - spread, 0, 127));
	endfunction

	// Readings come in short runs of one situation, so that the smoothed
	// distances settle and every action is reached, with pure noise mixed in.
	function automatic sonar_item_t next_reading();
		int          roll;
		sonar_item_t s;
		if (scene_left == 0) begin
			roll = $urandom_range(99);
			scene_left = $urandom_range(3, 14);
			scene_jit = 2;
			if (roll < 25) begin
				scene_base = '{$urandom_range(4, 16), $urandom_range(40, 127), $urandom_range(4, 16)};
			end else if (roll < 45) begin
				scene_base = '{$urandom_range(30, 127), $urandom_range(40, 127), $urandom_range(3, 20)};
				scene_jit = 3;
			end else if (roll < 60) begin
				scene_base = '{$urandom_range(2, 40), $urandom_range(3, 14), $urandom_range(2, 40)};
			end else if (roll < 70) begin
				scene_base = '{$urandom_range(20, 127), $urandom_range(20, 127),
					$urandom_range(20, 127)};
				scene_jit = 10;
			end else if (roll < 80) begin
				for (int i = 0; i < 3; i++)
					scene_base[i] = $urandom_range(1) ? $urandom_range(1, 2) : $urandom_range(10, 100);
				scene_jit = 1;
			end else if (roll < 85) begin
				for (int i = 0; i < 3; i++)
					scene_base[i] = $urandom_range(1) ? 0 : $urandom_range(1, 127);
				scene_jit = 0;
			end else begin
				scene_base = '{64, 64, 64};
				scene_jit = 64;
			end
		end
		scene_left--;
		s.left_raw_cm = jitter_cm(scene_base[0], scene_jit);
		s.front_raw_cm = jitter_cm(scene_base[1], scene_jit);
		s.right_raw_cm = jitter_cm(scene_base[2], scene_jit);
		return s;
	endfunction

	function automatic logic [CFG_W-1:0] reg_value(input setting_t how, input logic [CFG_W-1:0] dflt,
		input int typical);
		case (how)
			SET_MAX:     return '1;
			SET_ZERO:    return '0;
			SET_DEFAULT: return dflt;
			default:     return $urandom_range(3) == 0 ? CFG_W'($urandom) : CFG_W'($urandom_range(typical));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			REG_GAIN_P_TWO:  k_p_two = v;
			REG_GAIN_P_ONE:  k_p_one = v;
			REG_GAIN_D:      k_d = v;
			REG_GAIN_I:      k_i = v;
			REG_SIDE_LIMIT:  lim_side = v[DIST_W-1:0];
			REG_FRONT_LIMIT: lim_front = v[DIST_W-1:0];
			REG_TARGET_SIDE: want_side = v[DIST_W-1:0];
			default:         cruise = v[SPEED_W-1:0];
		endcase
		@(posedge clk);
	endtask

	task automatic apply_setting(input setting_t how);
		write_reg(REG_GAIN_P_TWO, reg_value(how, GAIN_P_TWO_RST, 6400));
		write_reg(REG_GAIN_P_ONE, reg_value(how, GAIN_P_ONE_RST, 4096));
		write_reg(REG_GAIN_D, reg_value(how, GAIN_D_RST, 1024));
		write_reg(REG_GAIN_I, reg_value(how, GAIN_I_RST, 256));
		write_reg(REG_SIDE_LIMIT, reg_value(how, SIDE_LIMIT_RST, 8000));
		write_reg(REG_FRONT_LIMIT, reg_value(how, FRONT_LIMIT_RST, 8000));
		write_reg(REG_TARGET_SIDE, reg_value(how, TARGET_SIDE_RST, 6000));
		write_reg(REG_BASE_SPEED, reg_value(how, BASE_SPEED_RST, 255));
		cfg_we <= 1'b0;
	endtask

	task automatic send_reading(input sonar_item_t s, input logic pinned, input steer_item_t want);
		steer_item_t modelled;
		while ($urandom_range(99) < idle_pct) begin
			sonar_valid <= 1'b0;
			@(posedge clk);
		end
		sonar <= s;
		sonar_valid <= 1'b1;
		@(posedge clk);
		while (!sonar_ready)
			@(posedge clk);
		modelled = predict_steer(s);
		steer_due.push_back(pinned ? want : modelled);
	endtask

	function automatic void note_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		steer_ready <= $urandom_range(99) >= stall_pct;
		if (arst_n && steer_valid && steer_ready) begin
			if (steer_due.size() == 0) begin
				errors++;
				$display("%0t: steering item %h with none expected", $time, steer);
			end else begin
				due_item = steer_due.pop_front();
				note_field("action_kind", due_item.action_kind, steer.action_kind);
				note_field("turn_kind", due_item.turn_kind, steer.turn_kind);
				note_field("escape_kind", due_item.escape_kind, steer.escape_kind);
				note_field("left_speed", due_item.left_speed, steer.left_speed);
				note_field("right_speed", due_item.right_speed, steer.right_speed);
				note_field("left_wall_seen", due_item.left_wall_seen, steer.left_wall_seen);
				note_field("right_wall_seen", due_item.right_wall_seen, steer.right_wall_seen);
				note_field("front_wall_seen", due_item.front_wall_seen, steer.front_wall_seen);
			end
		end
	end

	initial begin
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < PROBE_ROWS; i++)
			send_reading(PROBES[i].reading, PROBES[i].pinned, PROBES[i].want);
		for (int p = 0; p < PHASES; p++) begin
			sonar_valid <= 1'b0;
			while (steer_due.size() != 0)
				@(posedge clk);
			apply_setting(SETTING_PLAN[p]);
			idle_pct = IDLE_PLAN[p % 4];
			stall_pct = STALL_PLAN[p % 4];
			repeat (ITEMS_PER_PHASE)
				send_reading(next_reading(), 1'b0, '0);
		end
		sonar_valid <= 1'b0;
		while (steer_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
hdl/wfps_pkg.sv
hdl/wfps_div3.sv
hdl/wfps_mac.sv
hdl/wall_following_pid_steering.sv
tb/wall_following_pid_steering_test.sv
